// ===== src/pmp_pkg.sv =====
// pmp_pkg: types and constants for the peer message parser
// no dependencies; used by pmp_front, pmp_fifo and peer_message_parser
package pmp_pkg;

  typedef enum logic [2:0] {
    PH_LEN     = 3'd0,
    PH_ID      = 3'd1,
    PH_FIELD   = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_SKIP    = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    KIND_KEEPALIVE  = 4'd0,
    KIND_CHOKE      = 4'd1,
    KIND_UNCHOKE    = 4'd2,
    KIND_INTERESTED = 4'd3,
    KIND_NOTINTER   = 4'd4,
    KIND_HAVE       = 4'd5,
    KIND_BITFIELD   = 4'd6,
    KIND_REQUEST    = 4'd7,
    KIND_PIECE      = 4'd8,
    KIND_CANCEL     = 4'd9,
    KIND_PORT       = 4'd10,
    KIND_UNKNOWN    = 4'd11,
    KIND_PAYLOAD    = 4'd12
  } kind_t;

  // message ids on the wire
  localparam logic [7:0] CODE_NOTINTER = 8'd3;
  localparam logic [7:0] CODE_HAVE     = 8'd4;
  localparam logic [7:0] CODE_BITFIELD = 8'd5;
  localparam logic [7:0] CODE_REQUEST  = 8'd6;
  localparam logic [7:0] CODE_PIECE    = 8'd7;
  localparam logic [7:0] CODE_CANCEL   = 8'd8;
  localparam logic [7:0] CODE_PORT     = 8'd9;

  localparam logic [3:0] PREFIX_BYTES = 4'd4;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] piece_index;
    logic [31:0] block_begin;
    logic [31:0] block_length;
    logic [15:0] listen_port;
    logic [7:0]  payload_byte;
    logic        payload_last;
  } result_t;

  // field bytes following the id byte; zero for ids without fields
  function automatic logic [3:0] field_bytes(input logic [7:0] id);
    logic [3:0] n;
    n = 4'd0;
    unique case (id)
      CODE_HAVE:    n = 4'd4;
      CODE_REQUEST: n = 4'd12;
      CODE_PIECE:   n = 4'd8;
      CODE_CANCEL:  n = 4'd12;
      CODE_PORT:    n = 4'd2;
      default:      n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== src/pmp_front.sv =====
// pmp_front: byte-wise peer message parser, one result record per byte at most
// depends on pmp_pkg
module pmp_front import pmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [31:0] left_r, left_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] index_r, index_nxt;
  logic [31:0] begin_r, begin_nxt;

  logic [3:0]  count_inc;
  logic [31:0] left_dec;
  logic [31:0] shift_in;

  assign count_inc = count_r + 4'd1;
  assign left_dec  = (left_r != 32'd0) ? left_r - 32'd1 : left_r;
  assign shift_in  = {shift_r[23:0], rx_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      count_r <= 4'd0;
      left_r  <= 32'd0;
      id_r    <= 8'd0;
      shift_r <= 32'd0;
      index_r <= 32'd0;
      begin_r <= 32'd0;
    end else if (byte_valid) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      id_r    <= id_nxt;
      shift_r <= shift_nxt;
      index_r <= index_nxt;
      begin_r <= begin_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    left_nxt  = left_r;
    id_nxt    = id_r;
    shift_nxt = shift_r;
    index_nxt = index_r;
    begin_nxt = begin_r;
    res_valid = 1'b0;
    res       = '0;

    unique case (phase_r)
      PH_LEN: begin
        shift_nxt = shift_in;
        count_nxt = count_inc;
        if (count_inc >= PREFIX_BYTES) begin
          count_nxt = 4'd0;
          if (shift_in == 32'd0) begin
            res_valid = byte_valid;
            res.kind  = KIND_KEEPALIVE;
          end else begin
            left_nxt  = shift_in;
            phase_nxt = PH_ID;
          end
        end
      end

      PH_ID: begin
        id_nxt    = rx_byte;
        left_nxt  = left_dec;
        count_nxt = 4'd0;
        shift_nxt = 32'd0;
        if (rx_byte <= CODE_NOTINTER) begin
          res_valid = byte_valid;
          res.kind  = kind_t'(rx_byte[3:0] + 4'd1);
          phase_nxt = (left_dec == 32'd0) ? PH_LEN : PH_SKIP;
        end else if (rx_byte == CODE_BITFIELD) begin
          res_valid        = byte_valid;
          res.kind         = KIND_BITFIELD;
          res.block_length = left_dec;
          phase_nxt        = (left_dec == 32'd0) ? PH_LEN : PH_PAYLOAD;
        end else if (field_bytes(rx_byte) != 4'd0) begin
          phase_nxt = PH_FIELD;
        end else begin
          res_valid = byte_valid;
          res.kind  = KIND_UNKNOWN;
          phase_nxt = (left_dec == 32'd0) ? PH_LEN : PH_SKIP;
        end
      end

      PH_FIELD: begin
        shift_nxt = shift_in;
        left_nxt  = left_dec;
        count_nxt = count_inc;
        if (count_inc == 4'd4) begin
          index_nxt = shift_in;
        end else if (count_inc == 4'd8) begin
          begin_nxt = shift_in;
        end
        if (count_inc >= field_bytes(id_r)) begin
          count_nxt = 4'd0;
          res_valid = byte_valid;
          phase_nxt = (left_dec == 32'd0) ? PH_LEN : PH_SKIP;
          // index and begin come from next values: the final byte may load them
          priority case (id_r)
            CODE_HAVE: begin
              res.kind        = KIND_HAVE;
              res.piece_index = index_nxt;
            end
            CODE_PIECE: begin
              res.kind         = KIND_PIECE;
              res.piece_index  = index_nxt;
              res.block_begin  = begin_nxt;
              res.block_length = left_dec;
              phase_nxt        = (left_dec == 32'd0) ? PH_LEN : PH_PAYLOAD;
            end
            CODE_PORT: begin
              res.kind        = KIND_PORT;
              res.listen_port = shift_in[15:0];
            end
            default: begin
              res.kind         = (id_r == CODE_REQUEST) ? KIND_REQUEST : KIND_CANCEL;
              res.piece_index  = index_nxt;
              res.block_begin  = begin_nxt;
              res.block_length = shift_in;
            end
          endcase
        end
      end

      PH_PAYLOAD: begin
        res_valid        = byte_valid;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.payload_last = (left_r <= 32'd1);
        left_nxt         = left_dec;
        if (left_dec == 32'd0) begin
          phase_nxt = PH_LEN;
        end
      end

      PH_SKIP: begin
        left_nxt = left_dec;
        if (left_dec == 32'd0) begin
          phase_nxt = PH_LEN;
        end
      end

      default: begin
        phase_nxt = PH_LEN;
        count_nxt = 4'd0;
      end
    endcase
  end

endmodule

// ===== src/pmp_fifo.sv =====
// pmp_fifo: result queue between the parser and the result ports
// depends on pmp_pkg
module pmp_fifo import pmp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  result_t wr_data,
  output logic    full,
  input  logic    rd_en,
  output result_t rd_data,
  output logic    empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t       mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/peer_message_parser.sv =====
// channel  | handshake         | payload
// input    | push / full       | in_rx_byte
// result   | pop / empty       | out_msg_kind, out_piece_index, out_block_begin,
//          |                   | out_block_length, out_listen_port, out_payload_byte,
//          |                   | out_payload_last
// one byte is taken per clock while full is low; a result that it causes is
// written into the result queue in that cycle and reaches the result ports once
// the records ahead of it are popped. the result queue holds DEPTH records;
// full rises only when all are waiting to be popped, so a stalled consumer
// stops input after DEPTH results. reset clears parser state and the queue.
// depends on pmp_pkg, pmp_front, pmp_fifo
module peer_message_parser import pmp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  input  logic        pop,
  output logic        empty,
  output logic [3:0]  out_msg_kind,
  output logic [31:0] out_piece_index,
  output logic [31:0] out_block_begin,
  output logic [31:0] out_block_length,
  output logic [15:0] out_listen_port,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_last
);

  logic    take;
  logic    res_valid;
  result_t res;
  result_t head;

  assign take = push && !full;

  pmp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (take),
    .rx_byte    (in_rx_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  pmp_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .full    (full),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (empty)
  );

  assign out_msg_kind     = head.kind;
  assign out_piece_index  = head.piece_index;
  assign out_block_begin  = head.block_begin;
  assign out_block_length = head.block_length;
  assign out_listen_port  = head.listen_port;
  assign out_payload_byte = head.payload_byte;
  assign out_payload_last = head.payload_last;

endmodule
